### hdl/fel_pkg.sv
// Shared types, constants and binary32 arithmetic for the exp/log/pow unit.
// Depends on nothing; every other file imports it.
package fel_pkg;

   // command codes; the fourth code returns a zero word
   localparam logic [1:0] FEL_CMD_EXP = 2'd0;
   localparam logic [1:0] FEL_CMD_LOG = 2'd1;
   localparam logic [1:0] FEL_CMD_POW = 2'd2;

   localparam int FEL_LOG_STAGES = 10;
   localparam int FEL_EXP_STAGES = 12;
   localparam int FEL_LATENCY    = FEL_LOG_STAGES + 1 + FEL_EXP_STAGES;

   // binary32 constants
   localparam logic [31:0] FEL_C_K      = 32'h4B38AA3B; // 2^23 / ln2
   localparam logic [31:0] FEL_C_B127   = 32'h4E7E0000; // 127 * 2^23
   localparam logic [31:0] FEL_C_HI     = 32'h4EFF0000; // 255 * 2^23
   localparam logic [31:0] FEL_C_E4     = 32'h3C5E18ED;
   localparam logic [31:0] FEL_C_E3     = 32'hBB0F9081;
   localparam logic [31:0] FEL_C_E2     = 32'h3E2A9DAF;
   localparam logic [31:0] FEL_C_E1     = 32'h3E9FD1B2;
   localparam logic [31:0] FEL_C_E0     = 32'h3F0286E8;
   localparam logic [31:0] FEL_C_L5     = 32'h3CFECDDA;
   localparam logic [31:0] FEL_C_L4     = 32'hBE93D5B9;
   localparam logic [31:0] FEL_C_L3     = 32'h3F90B85C;
   localparam logic [31:0] FEL_C_L2     = 32'hC01D84AA;
   localparam logic [31:0] FEL_C_L1     = 32'h4061E022;
   localparam logic [31:0] FEL_C_LBIAS  = 32'hC2B3F107; // -89.970756366
   localparam logic [31:0] FEL_C_LN2    = 32'h3F317218;
   localparam logic [31:0] FEL_C_NINF   = 32'hFF800000;
   localparam logic [31:0] FEL_C_QNAN   = 32'h7FC00000;

   // word handed from the log pipeline to the power multiply
   typedef struct packed {
      logic        vld;
      logic [1:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] l;
   } fel_lrec_type;

   // word handed from the power multiply to the exp pipeline
   typedef struct packed {
      logic        vld;
      logic [1:0]  cmd;
      logic [31:0] m;
      logic [31:0] alt;
   } fel_xrec_type;

   // round to nearest even and pack; value = mant * 2^sc
   function automatic logic [31:0] fel_pack(logic sgn, logic signed [11:0] sc,
                                            logic [63:0] mant);
      logic [5:0]         lz;
      logic [63:0]        mn;
      logic [63:0]        msk;
      logic signed [11:0] be;
      logic [11:0]        sh;
      logic [24:0]        sig;
      logic               grd;
      logic               stk;
      logic               jam;
      logic [31:0]        res;
      lz = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mant[i]) lz = 6'(63 - i);
      end
      mn = mant << lz;
      be = sc + 12'sd190 - $signed({6'd0, lz});
      if (be < 12'sd1) begin
         sh = 12'(12'sd1 - be);
         if (sh > 12'd63) begin
            mn = 64'd1;
         end else begin
            msk = (64'd1 << sh[5:0]) - 64'd1;
            jam = |(mn & msk);
            mn  = (mn >> sh[5:0]) | {63'd0, jam};
         end
         be = 12'sd1;
      end
      sig = {1'b0, mn[63:40]};
      grd = mn[39];
      stk = |mn[38:0];
      if (grd && (stk || sig[0])) sig = sig + 25'd1;
      if (sig[24]) begin
         sig = sig >> 1;
         be  = be + 12'sd1;
      end
      if (mant == 64'd0) res = {sgn, 31'd0};
      else if (be >= 12'sd255) res = {sgn, 8'hFF, 23'd0};
      else res = {sgn, (sig[23] ? be[7:0] : 8'd0), sig[22:0]};
      return res;
   endfunction

   function automatic logic [31:0] fel_mul(logic [31:0] a, logic [31:0] b);
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, s;
      logic [7:0]  eea, eeb;
      logic [23:0] ma, mb;
      logic [47:0] prod;
      logic [31:0] res;
      nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      s      = a[31] ^ b[31];
      eea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eeb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma     = {(a[30:23] != 8'd0), a[22:0]};
      mb     = {(b[30:23] != 8'd0), b[22:0]};
      prod   = {24'd0, ma} * {24'd0, mb};
      if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) res = FEL_C_QNAN;
      else if (inf_a || inf_b) res = {s, 8'hFF, 23'd0};
      else if (zero_a || zero_b) res = {s, 31'd0};
      else res = fel_pack(s, $signed({4'd0, eea}) + $signed({4'd0, eeb}) - 12'sd300,
                          {16'd0, prod});
      return res;
   endfunction

   function automatic logic [31:0] fel_add(logic [31:0] a, logic [31:0] b);
      logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swp;
      logic [31:0] big, sml;
      logic [7:0]  eeg, ees, d;
      logic [63:0] mg, ms0, ms, sum;
      logic        jam;
      logic [31:0] res;
      nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      swp    = (b[30:0] > a[30:0]);
      big    = swp ? b : a;
      sml    = swp ? a : b;
      eeg    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      ees    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d      = eeg - ees;
      mg     = {10'd0, (big[30:23] != 8'd0), big[22:0], 30'd0};
      ms0    = {10'd0, (sml[30:23] != 8'd0), sml[22:0], 30'd0};
      if (d > 8'd63) begin
         ms = 64'd1;
      end else begin
         jam = |(ms0 & ((64'd1 << d[5:0]) - 64'd1));
         ms  = (ms0 >> d[5:0]) | {63'd0, jam};
      end
      sum = (big[31] == sml[31]) ? (mg + ms) : (mg - ms);
      if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) res = FEL_C_QNAN;
      else if (inf_a) res = a;
      else if (inf_b) res = b;
      else if (zero_a && zero_b) res = {a[31] & b[31], 31'd0};
      else if (zero_a) res = b;
      else if (zero_b) res = a;
      else if (sum == 64'd0) res = 32'd0;
      else res = fel_pack(big[31], $signed({4'd0, eeg}) - 12'sd180, sum);
      return res;
   endfunction

   // exact conversion of a 9-bit signed integer
   function automatic logic [31:0] fel_i2f(logic signed [8:0] e);
      logic [8:0] mag;
      mag = e[8] ? 9'(-e) : e;
      return fel_pack(e[8], 12'sd0, {55'd0, mag});
   endfunction

endpackage

### hdl/float_exp_log_pow_approx.sv
// Top level of the approximate exp/log/pow unit: log pipeline, power
// multiply stage and exp pipeline. Depends on fel_pkg, fel_log, fel_exp.
//
// Usage: drive req_cmd (0 exp of a, 1 natural log of a, 2 a raised to b,
// 3 returns zero), req_operand_a and req_operand_b with start high; busy is
// always low, so one word is accepted in every cycle that start is high.
// Each word passes through 23 register stages, mostly binary32 multiplies
// and adds (round to nearest even): ten for the logarithm, one for the
// power multiply and twelve for the exponential. The result appears on
// rsp_result with rsp_valid high for exactly one cycle, once the word has
// left the last stage, in order of acceptance. The receiver cannot stall the
// unit, so it must take every result in the cycle it is shown.
module float_exp_log_pow_approx import fel_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result
);

   fel_lrec_type log_rec;
   fel_xrec_type pow_ff;
   fel_xrec_type pow_in;

   // the pipeline never holds, so never refuse a word
   assign busy = 1'b0;

   fel_log u_log (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start & ~busy),
      .in_cmd  (req_cmd),
      .in_a    (req_operand_a),
      .in_b    (req_operand_b),
      .out_rec (log_rec)
   );

   // power multiply: b * ln(a) for pow, pass a straight through for exp;
   // hold the log result aside for the final select
   always_comb begin
      pow_in.vld = log_rec.vld;
      pow_in.cmd = log_rec.cmd;
      pow_in.alt = log_rec.l;
      case (log_rec.cmd)
         FEL_CMD_POW: pow_in.m = fel_mul(log_rec.b, log_rec.l);
         default:     pow_in.m = log_rec.a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pow_ff <= '0;
      else pow_ff <= pow_in;
   end

   fel_exp u_exp (
      .clock      (clock),
      .reset      (reset),
      .in_rec     (pow_ff),
      .out_vld    (rsp_valid),
      .out_result (rsp_result)
   );

   // every accepted word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##FEL_LATENCY rsp_valid)
      else $error("result missing after accepted word");

   // no result without a word accepted at the matching time
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, FEL_LATENCY))
      else $error("result without accepted word");

   // log of a word with the sign bit set is minus infinity
   a_log_neg: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == FEL_CMD_LOG) && req_operand_a[31])
      |-> ##FEL_LATENCY (rsp_result == FEL_C_NINF))
      else $error("log of negative word not minus infinity");

   // unused command returns zero
   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd != FEL_CMD_EXP) && (req_cmd != FEL_CMD_LOG) &&
       (req_cmd != FEL_CMD_POW)) |-> ##FEL_LATENCY (rsp_result == 32'd0))
      else $error("unused command gave nonzero result");

endmodule

### hdl/fel_log.sv
// Ten-stage logarithm pipeline: one or two binary32 multiplies or adds per stage.
// Depends on fel_pkg.
module fel_log import fel_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_vld,
   input  logic [1:0]   in_cmd,
   input  logic [31:0]  in_a,
   input  logic [31:0]  in_b,
   output fel_lrec_type out_rec
);

   typedef struct packed {
      logic        vld;
      logic [1:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] x;
      logic [31:0] bias;
      logic [31:0] p;
      logic [31:0] q;
   } fel_lst_type;

   fel_lst_type st_ff [1:FEL_LOG_STAGES];
   fel_lst_type st_in [1:FEL_LOG_STAGES];

   logic a_pos;

   // strictly positive, NaN excluded
   assign a_pos = !in_a[31] && (in_a[30:0] != 31'd0) &&
                  !((in_a[30:23] == 8'hFF) && (in_a[22:0] != 23'd0));

   always_comb begin
      st_in[1].vld  = in_vld;
      st_in[1].cmd  = in_cmd;
      st_in[1].a    = in_a;
      st_in[1].b    = in_b;
      st_in[1].x    = {9'h07F, in_a[22:0]};
      st_in[1].bias = a_pos ? FEL_C_LBIAS : FEL_C_NINF;
      st_in[1].p    = fel_mul({9'h07F, in_a[22:0]}, FEL_C_L5);
      st_in[1].q    = fel_mul(FEL_C_LN2, fel_i2f($signed(in_a[31:23])));
      for (int k = 2; k <= FEL_LOG_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         case (k)
            2: begin
               st_in[k].p = fel_add(FEL_C_L4, st_ff[k-1].p);
               st_in[k].q = fel_add(st_ff[k-1].bias, st_ff[k-1].q);
            end
            3, 5, 7, 9: st_in[k].p = fel_mul(st_ff[k-1].x, st_ff[k-1].p);
            4:  st_in[k].p = fel_add(FEL_C_L3, st_ff[k-1].p);
            6:  st_in[k].p = fel_add(FEL_C_L2, st_ff[k-1].p);
            8:  st_in[k].p = fel_add(FEL_C_L1, st_ff[k-1].p);
            10: st_in[k].p = fel_add(st_ff[k-1].p, st_ff[k-1].q);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= FEL_LOG_STAGES; k++) begin
         if (reset) st_ff[k] <= '0;
         else st_ff[k] <= st_in[k];
      end
   end

   assign out_rec.vld = st_ff[FEL_LOG_STAGES].vld;
   assign out_rec.cmd = st_ff[FEL_LOG_STAGES].cmd;
   assign out_rec.a   = st_ff[FEL_LOG_STAGES].a;
   assign out_rec.b   = st_ff[FEL_LOG_STAGES].b;
   assign out_rec.l   = st_ff[FEL_LOG_STAGES].p;

endmodule

### hdl/fel_exp.sv
// Twelve-stage exponential pipeline with final result select.
// Depends on fel_pkg.
module fel_exp import fel_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fel_xrec_type in_rec,
   output logic         out_vld,
   output logic [31:0]  out_result
);

   typedef struct packed {
      logic        vld;
      logic [1:0]  cmd;
      logic [31:0] alt;
      logic [31:0] s;
      logic [31:0] p2;
      logic [31:0] bm;
      logic [31:0] t;
   } fel_xst_type;

   fel_xst_type st_ff [1:FEL_EXP_STAGES];
   fel_xst_type st_in [1:FEL_EXP_STAGES];

   logic [31:0] clamp_hi;
   logic [31:0] clamp_c;
   logic [4:0]  trunc_sh;
   logic [31:0] trunc_n;

   // clamp to 0 .. 255*2^23 (NaN goes high) and truncate to an integer
   always_comb begin
      if ((st_ff[2].s[30:23] == 8'hFF) && (st_ff[2].s[22:0] != 23'd0))
         clamp_hi = FEL_C_HI;
      else if (st_ff[2].s[31] || (st_ff[2].s[30:0] < FEL_C_HI[30:0]))
         clamp_hi = st_ff[2].s;
      else
         clamp_hi = FEL_C_HI;
      clamp_c  = (!clamp_hi[31] && (clamp_hi[30:0] != 31'd0)) ? clamp_hi : 32'd0;
      trunc_sh = 5'(8'd158 - clamp_c[30:23]);
      if (clamp_c[30:23] < 8'd127) trunc_n = 32'd0;
      else trunc_n = {1'b1, clamp_c[22:0], 8'd0} >> trunc_sh;
   end

   always_comb begin
      st_in[1].vld = in_rec.vld;
      st_in[1].cmd = in_rec.cmd;
      st_in[1].alt = in_rec.alt;
      st_in[1].s   = fel_mul(FEL_C_K, in_rec.m);
      st_in[1].p2  = 32'd0;
      st_in[1].bm  = 32'd0;
      st_in[1].t   = 32'd0;
      for (int k = 2; k <= FEL_EXP_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         case (k)
            2: st_in[k].s = fel_add(st_ff[k-1].s, FEL_C_B127);
            3: begin
               st_in[k].p2 = trunc_n & 32'h7F800000;
               st_in[k].bm = {9'h07F, trunc_n[22:0]};
            end
            4:  st_in[k].t = fel_mul(st_ff[k-1].bm, FEL_C_E4);
            6, 8, 10: st_in[k].t = fel_mul(st_ff[k-1].bm, st_ff[k-1].t);
            5:  st_in[k].t = fel_add(FEL_C_E3, st_ff[k-1].t);
            7:  st_in[k].t = fel_add(FEL_C_E2, st_ff[k-1].t);
            9:  st_in[k].t = fel_add(FEL_C_E1, st_ff[k-1].t);
            11: st_in[k].t = fel_add(FEL_C_E0, st_ff[k-1].t);
            12: begin
               case (st_ff[k-1].cmd)
                  FEL_CMD_EXP, FEL_CMD_POW:
                     st_in[k].t = fel_mul(st_ff[k-1].p2, st_ff[k-1].t);
                  FEL_CMD_LOG: st_in[k].t = st_ff[k-1].alt;
                  default:     st_in[k].t = 32'd0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= FEL_EXP_STAGES; k++) begin
         if (reset) st_ff[k] <= '0;
         else st_ff[k] <= st_in[k];
      end
   end

   assign out_vld    = st_ff[FEL_EXP_STAGES].vld;
   assign out_result = st_ff[FEL_EXP_STAGES].t;

endmodule
